>>> hw/rtl/tsps_pkg.sv
// Shared types and codes for the TAP scan pin sequencer.
// No dependencies.
`timescale 1ns / 1ps

package tsps_pkg;

   localparam int CMD_W       = 3;
   localparam int KIND_W      = 2;
   localparam int CNT_W       = 7;
   localparam int DATA_W      = 64;
   localparam int MAX_BITS    = 64;
   localparam int QUEUE_DEPTH = 2;

   // request codes on req_cmd
   localparam logic [CMD_W-1:0] CMD_DR    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_IR    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_OTHER = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TDO   = 3'd4;

   // classified operations passed from front to back
   localparam logic [CMD_W-1:0] OP_DR    = 3'd0;
   localparam logic [CMD_W-1:0] OP_IR    = 3'd1;
   localparam logic [CMD_W-1:0] OP_CLOSE = 3'd2;
   localparam logic [CMD_W-1:0] OP_OTHER = 3'd3;
   localparam logic [CMD_W-1:0] OP_TDO   = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_PIN   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic [CNT_W-1:0] count;   // already saturated
      logic             tdo;
   } entry_type;

endpackage

>>> hw/rtl/tap_scan_pin_sequencer.sv
// Items pass the queue, then the result register. One pin cycle per returned tdo item.
// Throughput: one item per cycle while unstalled; a two-entry queue between the decode
// front and the sequencing back end lets either side stall alone.
// Reset: synchronous, active high; queue empty, sequencer idle, no result pending.
// Top level: tsps_front, tsps_back; depends on tsps_pkg.
`timescale 1ns / 1ps

module tap_scan_pin_sequencer #(
   parameter int MAX_SCAN_BITS = tsps_pkg::MAX_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tsps_pkg::CMD_W-1:0]     req_cmd,
   input  logic [tsps_pkg::CNT_W-1:0]     req_bit_count,
   input  logic [tsps_pkg::DATA_W-1:0]    req_scan_data,
   input  logic                           req_tdo,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tsps_pkg::KIND_W-1:0]    rsp_kind,
   output logic                           rsp_tdi,
   output logic                           rsp_tms,
   output logic [tsps_pkg::DATA_W-1:0]    rsp_captured,
   output logic [tsps_pkg::CNT_W-1:0]     rsp_captured_count
);
   import tsps_pkg::*;

   logic                     q_valid;
   entry_type                q_entry;
   logic [MAX_SCAN_BITS-1:0] q_data;
   logic                     q_pop;

   tsps_front #(
      .MAX_SCAN_BITS (MAX_SCAN_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_bit_count (req_bit_count),
      .req_scan_data (req_scan_data),
      .req_tdo       (req_tdo),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_data        (q_data),
      .q_pop         (q_pop)
   );

   tsps_back #(
      .MAX_SCAN_BITS (MAX_SCAN_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_entry            (q_entry),
      .q_data             (q_data),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_tdi            (rsp_tdi),
      .rsp_tms            (rsp_tms),
      .rsp_captured       (rsp_captured),
      .rsp_captured_count (rsp_captured_count)
   );

endmodule

>>> hw/rtl/tsps_front.sv
// Front end: accepts request items, classifies them and queues them.
// Depends on tsps_pkg.
`timescale 1ns / 1ps

module tsps_front #(
   parameter int MAX_SCAN_BITS = tsps_pkg::MAX_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tsps_pkg::CMD_W-1:0]     req_cmd,
   input  logic [tsps_pkg::CNT_W-1:0]     req_bit_count,
   input  logic [tsps_pkg::DATA_W-1:0]    req_scan_data,
   input  logic                           req_tdo,
   output logic                           q_valid,
   output tsps_pkg::entry_type            q_entry,
   output logic [MAX_SCAN_BITS-1:0]       q_data,
   input  logic                           q_pop
);
   import tsps_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SCAN_BITS);

   entry_type                entry_ff [QUEUE_DEPTH];
   logic [MAX_SCAN_BITS-1:0] data_ff  [QUEUE_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   entry_type                new_entry;
   logic                     push;
   logic                     pop;

   always_comb begin
      new_entry.tdo = req_tdo;
      new_entry.count = (req_bit_count > MAX_CNT) ? MAX_CNT : req_bit_count;
      case (req_cmd)
         CMD_DR:    new_entry.op = OP_DR;
         CMD_IR:    new_entry.op = OP_IR;
         CMD_CLOSE: new_entry.op = OP_CLOSE;
         CMD_TDO:   new_entry.op = OP_TDO;
         default:   new_entry.op = OP_OTHER;
      endcase
   end

   assign req_stall = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = entry_ff[rd_ptr_ff];
   assign q_data    = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
         data_ff[wr_ptr_ff]  <= req_scan_data[MAX_SCAN_BITS-1:0];
      end
   end

endmodule

>>> hw/rtl/tsps_back.sv
// Back end: runs the TAP pin sequence for queued items and holds the result register.
// Depends on tsps_pkg.
`timescale 1ns / 1ps

module tsps_back #(
   parameter int MAX_SCAN_BITS = tsps_pkg::MAX_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  tsps_pkg::entry_type            q_entry,
   input  logic [MAX_SCAN_BITS-1:0]       q_data,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tsps_pkg::KIND_W-1:0]    rsp_kind,
   output logic                           rsp_tdi,
   output logic                           rsp_tms,
   output logic [tsps_pkg::DATA_W-1:0]    rsp_captured,
   output logic [tsps_pkg::CNT_W-1:0]     rsp_captured_count
);
   import tsps_pkg::*;

   localparam int IDX_W = (MAX_SCAN_BITS > 1) ? $clog2(MAX_SCAN_BITS) : 1;

   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_PRE1  = 4'd1;
   localparam logic [3:0] PH_PREIR = 4'd2;
   localparam logic [3:0] PH_CAP   = 4'd3;
   localparam logic [3:0] PH_SHIFT = 4'd4;
   localparam logic [3:0] PH_DATA  = 4'd5;
   localparam logic [3:0] PH_EXIT  = 4'd6;
   localparam logic [3:0] PH_UPD   = 4'd7;
   localparam logic [3:0] PH_RTI   = 4'd8;

   logic [3:0]               phase_ff, phase_in;
   logic                     is_ir_ff, is_ir_in;
   logic [MAX_SCAN_BITS-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic [CNT_W-1:0]         len_ff, len_in;
   logic [MAX_SCAN_BITS-1:0] cap_ff, cap_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]        kind_ff;
   logic                     tdi_ff;
   logic                     tms_ff;
   logic [DATA_W-1:0]        captured_ff;
   logic [CNT_W-1:0]         count_ff;

   logic                     take;
   logic                     res_valid;
   logic [KIND_W-1:0]        res_kind;
   logic                     res_tdi;
   logic                     res_tms;
   logic                     res_done;
   logic [CNT_W-1:0]         left_m1;
   logic [CNT_W-1:0]         len_diff;
   logic [DATA_W-1:0]        cap_ext;

   assign take  = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = take;

   always_comb begin
      cap_ext = '0;
      cap_ext[MAX_SCAN_BITS-1:0] = cap_ff;
   end

   always_comb begin
      phase_in  = phase_ff;
      is_ir_in  = is_ir_ff;
      shift_in  = shift_ff;
      left_in   = left_ff;
      len_in    = len_ff;
      cap_in    = cap_ff;
      res_valid = 1'b0;
      res_kind  = KIND_PIN;
      res_tdi   = 1'b0;
      res_tms   = 1'b0;
      res_done  = 1'b0;
      left_m1   = '0;
      len_diff  = len_ff - left_ff;
      if (phase_ff == PH_IDLE) begin
         case (q_entry.op)
            OP_TDO: begin
               res_valid = 1'b0;
            end
            OP_CLOSE: begin
               res_valid = 1'b1;
               res_kind  = KIND_CLOSE;
            end
            OP_DR, OP_IR: begin
               res_valid = 1'b1;
               res_tms   = 1'b1;
               is_ir_in  = (q_entry.op == OP_IR);
               shift_in  = q_data;
               left_in   = q_entry.count;
               len_in    = q_entry.count;
               cap_in    = '0;
               phase_in  = PH_PRE1;
            end
            default: begin
               res_valid = 1'b1;
               res_kind  = KIND_DONE;
            end
         endcase
      end else if (q_entry.op == OP_TDO) begin
         res_valid = 1'b1;
         case (phase_ff)
            PH_PRE1: begin
               res_tms  = is_ir_ff;
               phase_in = is_ir_ff ? PH_PREIR : PH_CAP;
            end
            PH_PREIR: phase_in = PH_CAP;
            PH_CAP:   phase_in = PH_SHIFT;
            PH_SHIFT, PH_DATA: begin
               if (phase_ff == PH_DATA && left_ff != '0) begin
                  cap_in[len_diff[IDX_W-1:0]] = cap_ff[len_diff[IDX_W-1:0]] | q_entry.tdo;
                  left_in = left_ff - 1'b1;
               end
               if (left_in != '0) begin
                  left_m1  = left_in - 1'b1;
                  res_tdi  = shift_ff[left_m1[IDX_W-1:0]];
                  phase_in = PH_DATA;
               end else begin
                  res_tms  = 1'b1;
                  phase_in = PH_EXIT;
               end
            end
            PH_EXIT: begin
               res_tms  = 1'b1;
               phase_in = PH_UPD;
            end
            PH_UPD:   phase_in = PH_RTI;
            PH_RTI: begin
               res_kind = KIND_DONE;
               res_done = 1'b1;
               phase_in = PH_IDLE;
            end
            default: begin
               res_valid = 1'b0;
               phase_in  = PH_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid_in = take ? res_valid : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         is_ir_ff     <= 1'b0;
         shift_ff     <= '0;
         left_ff      <= '0;
         len_ff       <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            is_ir_ff <= is_ir_in;
            shift_ff <= shift_in;
            left_ff  <= left_in;
            len_ff   <= len_in;
            cap_ff   <= cap_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         kind_ff     <= res_kind;
         tdi_ff      <= res_tdi;
         tms_ff      <= res_tms;
         captured_ff <= res_done ? cap_ext : '0;
         count_ff    <= res_done ? len_ff : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_tdi            = tdi_ff;
   assign rsp_tms            = tms_ff;
   assign rsp_captured       = captured_ff;
   assign rsp_captured_count = count_ff;

endmodule
